[sv/tpcl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpcl_pkg
// Shared sizes, types and codes for the threshold promote list.
// ----------------------------------------------------------------------------
package tpcl_pkg;

   localparam int DEPTH      = 16;
   localparam int KEY_WIDTH  = 32;
   localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int OCC_W      = $clog2(DEPTH + 1);
   localparam int KEY_IN_W   = 32;
   localparam int COUNT_W    = 16;
   localparam int THR_W      = 16;
   localparam int CAP_W      = 5;
   localparam int OCC_OUT_W  = 5;
   localparam int CSR_DATA_W = 16;

   localparam logic [COUNT_W-1:0] COUNT_MAX     = {COUNT_W{1'b1}};
   localparam logic [THR_W-1:0]   THR_RESET     = THR_W'(3);
   localparam logic [CAP_W-1:0]   CAP_RESET     = CAP_W'(16);

   typedef logic [KEY_WIDTH-1:0] key_type;
   typedef logic [COUNT_W-1:0]   count_type;
   typedef logic [OCC_W-1:0]     occ_type;
   typedef logic [DEPTH-1:0]     entry_vec_type;

   typedef enum logic {
      OP_ACCESS = 1'b0,
      OP_FLUSH  = 1'b1
   } opcode_type;

   typedef enum logic {
      CSR_HIT_THRESHOLD = 1'b0,
      CSR_CAPACITY      = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } cmd_type;

endpackage

[sv/tpcl_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpcl channel interfaces
// Request and response channels with valid/ready handshake and payload.
// ----------------------------------------------------------------------------
interface tpcl_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [31:0] key;

   modport source (output valid, output opcode, output key, input ready);
   modport sink   (input valid, input opcode, input key, output ready);
endinterface

interface tpcl_rsp_if;
   logic        valid;
   logic        ready;
   logic        hit;
   logic [15:0] hit_count;
   logic        promoted;
   logic        evicted;
   logic [31:0] evicted_key;
   logic [4:0]  occupancy;

   modport source (output valid, output hit, output hit_count, output promoted,
                   output evicted, output evicted_key, output occupancy,
                   input ready);
   modport sink   (input valid, input hit, input hit_count, input promoted,
                   input evicted, input evicted_key, input occupancy,
                   output ready);
endinterface

[sv/tpcl_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpcl_ctrl
// Sequencer: accept a request, then commit the update when the response
// register is free.
// ----------------------------------------------------------------------------
module tpcl_ctrl
   import tpcl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_UPDATE
   } state_type;

   state_type state_ff;
   logic      req_ready_ff;
   logic      rsp_valid_ff;

   always_comb begin
      cmd.capture = req_valid && req_ready_ff;
      cmd.commit  = (state_ff == ST_UPDATE) && (!rsp_valid_ff || rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_ready && !cmd.commit) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd.capture) begin
                  state_ff     <= ST_UPDATE;
                  req_ready_ff <= 1'b0;
               end else begin
                  req_ready_ff <= 1'b1;
               end
            end
            ST_UPDATE: begin
               if (cmd.commit) begin
                  state_ff     <= ST_IDLE;
                  req_ready_ff <= 1'b1;
                  rsp_valid_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

[sv/tpcl_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpcl_datapath
// Ordered entry registers, parallel key compare, shift update, config
// registers and response register.
// ----------------------------------------------------------------------------
module tpcl_datapath
   import tpcl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   input  logic                  csr_we,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_opcode,
   input  logic [KEY_IN_W-1:0]   req_key,
   output logic                  rsp_hit,
   output logic [COUNT_W-1:0]    rsp_hit_count,
   output logic                  rsp_promoted,
   output logic                  rsp_evicted,
   output logic [KEY_IN_W-1:0]   rsp_evicted_key,
   output logic [OCC_OUT_W-1:0]  rsp_occupancy
);

   key_type         keys_ff   [DEPTH];
   count_type       counts_ff [DEPTH];
   key_type         keys_in   [DEPTH];
   count_type       counts_in [DEPTH];
   occ_type         occ_ff, occ_in;
   logic [THR_W-1:0] thr_ff;
   logic [CAP_W-1:0] cap_ff;

   logic            lk_flush_ff;
   key_type         lk_key_ff;
   entry_vec_type   lk_first_ff;
   logic            lk_full_ff;
   key_type         lk_evk_ff;

   logic                 out_hit_ff;
   count_type            out_count_ff;
   logic                 out_promoted_ff;
   logic                 out_evicted_ff;
   logic [KEY_IN_W-1:0]  out_evk_ff;
   logic [OCC_OUT_W-1:0] out_occ_ff;

   key_type       lk_key;
   entry_vec_type lk_eq;
   entry_vec_type lk_first;
   occ_type       eff_cap;
   logic          lk_full;
   logic [IDX_W-1:0] last_idx;

   logic          hit;
   count_type     cnt_sel;
   count_type     cnt_inc;
   logic          promote;
   entry_vec_type le_pos;
   logic          evicted;
   count_type     out_count;

   // lookup against the current entries
   always_comb begin
      lk_key = key_type'(req_key);
      for (int i = 0; i < DEPTH; i++) begin
         lk_eq[i] = (occ_type'(i) < occ_ff) && (keys_ff[i] == lk_key);
      end
      lk_first = lk_eq & (~lk_eq + entry_vec_type'(1));
      if (cap_ff == '0) begin
         eff_cap = occ_type'(1);
      end else if (int'(cap_ff) > DEPTH) begin
         eff_cap = occ_type'(DEPTH);
      end else begin
         eff_cap = occ_type'(cap_ff);
      end
      lk_full  = (occ_ff >= eff_cap) && (occ_ff != '0);
      last_idx = IDX_W'(occ_ff - occ_type'(1));
   end

   // update from the captured lookup
   always_comb begin
      hit     = |lk_first_ff;
      cnt_sel = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (lk_first_ff[i]) begin
            cnt_sel = cnt_sel | counts_ff[i];
         end
         le_pos[i] = (lk_first_ff >> i) != '0;
      end
      cnt_inc = (cnt_sel == COUNT_MAX) ? cnt_sel : cnt_sel + count_type'(1);
      promote = hit && (cnt_inc > thr_ff) && !lk_first_ff[0];
      evicted = !lk_flush_ff && !hit && lk_full_ff;

      for (int i = 0; i < DEPTH; i++) begin
         keys_in[i]   = keys_ff[i];
         counts_in[i] = counts_ff[i];
      end
      occ_in    = occ_ff;
      out_count = '0;

      if (lk_flush_ff) begin
         occ_in = '0;
      end else if (hit) begin
         out_count = cnt_inc;
         if (promote) begin
            for (int i = 1; i < DEPTH; i++) begin
               if (le_pos[i]) begin
                  keys_in[i]   = keys_ff[i-1];
                  counts_in[i] = counts_ff[i-1];
               end
            end
            keys_in[0]   = lk_key_ff;
            counts_in[0] = cnt_inc;
         end else begin
            for (int i = 0; i < DEPTH; i++) begin
               if (lk_first_ff[i]) begin
                  counts_in[i] = cnt_inc;
               end
            end
         end
      end else begin
         out_count = count_type'(1);
         for (int i = 1; i < DEPTH; i++) begin
            keys_in[i]   = keys_ff[i-1];
            counts_in[i] = counts_ff[i-1];
         end
         keys_in[0]   = lk_key_ff;
         counts_in[0] = count_type'(1);
         if (!lk_full_ff) begin
            occ_in = occ_ff + occ_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
         thr_ff <= THR_RESET;
         cap_ff <= CAP_RESET;
      end else begin
         if (cmd.commit) begin
            occ_ff <= occ_in;
         end
         if (csr_we) begin
            unique case (csr_index)
               CSR_HIT_THRESHOLD: thr_ff <= csr_wdata[THR_W-1:0];
               CSR_CAPACITY:      cap_ff <= csr_wdata[CAP_W-1:0];
               default:           ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         lk_flush_ff <= (opcode_type'(req_opcode) == OP_FLUSH);
         lk_key_ff   <= lk_key;
         lk_first_ff <= lk_first;
         lk_full_ff  <= lk_full;
         lk_evk_ff   <= keys_ff[last_idx];
      end
      if (cmd.commit) begin
         for (int i = 0; i < DEPTH; i++) begin
            keys_ff[i]   <= keys_in[i];
            counts_ff[i] <= counts_in[i];
         end
         out_hit_ff      <= hit && !lk_flush_ff;
         out_count_ff    <= out_count;
         out_promoted_ff <= promote && !lk_flush_ff;
         out_evicted_ff  <= evicted;
         out_evk_ff      <= evicted ? KEY_IN_W'(lk_evk_ff) : '0;
         out_occ_ff      <= OCC_OUT_W'(occ_in);
      end
   end

   assign rsp_hit         = out_hit_ff;
   assign rsp_hit_count   = out_count_ff;
   assign rsp_promoted    = out_promoted_ff;
   assign rsp_evicted     = out_evicted_ff;
   assign rsp_evicted_key = out_evk_ff;
   assign rsp_occupancy   = out_occ_ff;

endmodule

[sv/threshold_promote_cache_list.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// threshold_promote_cache_list
// Move-to-front list of address keys with per-entry saturating hit counters.
// ----------------------------------------------------------------------------
// Each request passes an accept step and an update step: on accept, the key is
// compared against all valid entries at once and the match is captured; on
// update, the ordered entry registers shift or update and the response register
// loads. A request can be accepted while the previous response still waits;
// its update then holds until that response transfers. Configuration writes
// take effect at the next clock edge and are meant for idle periods.
module threshold_promote_cache_list
   import tpcl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   tpcl_req_if.sink              req_ch,
   tpcl_rsp_if.source            rsp_ch,
   input  logic                  csr_we,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type cmd;

   tpcl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   tpcl_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_opcode      (req_ch.opcode),
      .req_key         (req_ch.key),
      .rsp_hit         (rsp_ch.hit),
      .rsp_hit_count   (rsp_ch.hit_count),
      .rsp_promoted    (rsp_ch.promoted),
      .rsp_evicted     (rsp_ch.evicted),
      .rsp_evicted_key (rsp_ch.evicted_key),
      .rsp_occupancy   (rsp_ch.occupancy)
   );

endmodule

[sv/tpcl_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpcl_checker
// Port-level checks of the threshold promote list, bound to the top level.
// ----------------------------------------------------------------------------
module tpcl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_hit,
   input logic [15:0] rsp_hit_count,
   input logic        rsp_promoted,
   input logic        rsp_evicted,
   input logic [31:0] rsp_evicted_key,
   input logic [4:0]  rsp_occupancy
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit)
         && $stable(rsp_hit_count) && $stable(rsp_promoted) && $stable(rsp_evicted)
         && $stable(rsp_evicted_key) && $stable(rsp_occupancy))
      else $error("response changed while stalled");

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted in back-to-back cycles");

   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("response appeared without a request two cycles earlier");

endmodule

bind threshold_promote_cache_list tpcl_checker u_tpcl_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_hit         (rsp_ch.hit),
   .rsp_hit_count   (rsp_ch.hit_count),
   .rsp_promoted    (rsp_ch.promoted),
   .rsp_evicted     (rsp_ch.evicted),
   .rsp_evicted_key (rsp_ch.evicted_key),
   .rsp_occupancy   (rsp_ch.occupancy)
);
